// File: hw/rtl/gesq_pkg.sv
// ----------------------------------------------------------------------------
// GPS ENU sample queue package
// Shared types, widths and fixed-point constants.
// ----------------------------------------------------------------------------
`default_nettype none
package gesq_pkg;

  localparam int unsigned QueueDepth = 50;
  localparam int unsigned PtrW       = 6;

  // request codes carried on the input tuser
  localparam logic OpPush = 1'b0;
  localparam logic OpPop  = 1'b1;

  // mm per 1e-7 degree (Q32) and radians per 1e-7 degree (Q62)
  localparam logic [63:0] PiQ60      = 64'h3243F6A8885A308D;
  localparam logic [63:0] MmPerUnitQ32 =
      64'((((PiQ60 >> 28) * 64'd6378137) + 64'd900000) / 64'd1800000);
  localparam logic [63:0] RadPerUnitQ62 = 64'((PiQ60 + 64'd225000000) / 64'd450000000);
  localparam logic signed [63:0] OneQ30 = 64'sd1073741824;

  // scale of the divisor reciprocals
  localparam logic [5:0] RcpShift = 6'd40;

  // entry word: valid, time, lat, lon, alt, up, east, north
  localparam int unsigned EntryW = 1 + 63 + 31 + 32 + 28 + 28 + 37 + 36;

  typedef struct packed {
    logic               valid;
    logic [62:0]        fix_time;
    logic signed [30:0] lat;
    logic signed [31:0] lon;
    logic signed [27:0] alt;
    logic signed [27:0] up;
    logic signed [36:0] east;
    logic signed [35:0] north;
  } entry_t;

  typedef enum logic [3:0] {
    StIdle, StCosTh, StCosX2, StCosLoop, StCosRcp, StCosDiv, StNorth, StEastG,
    StEastM, StWrite, StPopRd, StPopOut
  } state_e;

  // rounding divisors (2k)(2k-1) for k = 1..9
  function automatic logic [8:0] cos_div(input logic [3:0] k);
    logic [8:0] d;
    d = 9'd0;
    case (k)
      4'd1: d = 9'd2;
      4'd2: d = 9'd12;
      4'd3: d = 9'd30;
      4'd4: d = 9'd56;
      4'd5: d = 9'd90;
      4'd6: d = 9'd132;
      4'd7: d = 9'd182;
      4'd8: d = 9'd240;
      4'd9: d = 9'd306;
      default: d = 9'd1;
    endcase
    return d;
  endfunction

  // reciprocals floor(2^40 / ((2k)(2k-1))) for k = 1..9
  function automatic logic [63:0] cos_rcp(input logic [3:0] k);
    logic [63:0] r;
    r = 64'd0;
    case (k)
      4'd1: r = (64'd1 << 40) / 64'd2;
      4'd2: r = (64'd1 << 40) / 64'd12;
      4'd3: r = (64'd1 << 40) / 64'd30;
      4'd4: r = (64'd1 << 40) / 64'd56;
      4'd5: r = (64'd1 << 40) / 64'd90;
      4'd6: r = (64'd1 << 40) / 64'd132;
      4'd7: r = (64'd1 << 40) / 64'd182;
      4'd8: r = (64'd1 << 40) / 64'd240;
      4'd9: r = (64'd1 << 40) / 64'd306;
      default: r = 64'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/gesq_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One write or one read per cycle, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module gesq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // write or read the addressed word
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule
`default_nettype wire

// File: hw/rtl/gesq_mul.sv
// ----------------------------------------------------------------------------
// Shared rounding multiplier
// Computes round(a*b / 2^s) over four 32x32 partial products, one per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module gesq_mul (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [63:0] a_i,
  input  wire logic [63:0] b_i,
  input  wire logic [5:0]  shift_i,
  output logic             done_o,
  output logic [63:0]      res_o
);
  logic [63:0]  a_q, b_q;
  logic [5:0]   s_q;
  logic [2:0]   step_q, step_d;
  logic [127:0] acc_q, acc_d;
  logic         busy_q, busy_d;
  logic [31:0]  op_a, op_b;
  logic [63:0]  pp;
  logic [127:0] rnd;

  // choose one partial product per step
  always_comb begin
    op_a = step_q[1] ? a_q[63:32] : a_q[31:0];
    op_b = step_q[0] ? b_q[63:32] : b_q[31:0];
    pp   = 64'(op_a) * 64'(op_b);
  end

  // accumulate partial products
  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    acc_d  = acc_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = 3'd0;
      acc_d  = 128'd0;
    end else if (busy_q) begin
      acc_d  = acc_q + (128'(pp) << (7'(step_q[1]) * 7'd32 + 7'(step_q[0]) * 7'd32));
      step_d = step_q + 3'd1;
      if (step_q == 3'd3) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= 3'd0;
      done_o <= 1'b0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
      done_o <= busy_q && (step_q == 3'd3);
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (start_i) begin
      a_q <= a_i;
      b_q <= b_i;
      s_q <= shift_i;
    end
  end

  // round half up and shift
  assign rnd   = acc_q + (128'd1 << (s_q - 6'd1));
  assign res_o = 64'(rnd >> s_q);
endmodule
`default_nettype wire

// File: hw/rtl/gps_enu_sample_queue_unit.sv
// ----------------------------------------------------------------------------
// GPS ENU sample queue
// Converts GPS fixes to flat-earth ENU millimetres and queues them.
// ----------------------------------------------------------------------------
// Usage: s_axis carries requests. tuser = operation (0 push, 1 pop); tdata
// holds fix_valid, fix_time, latitude, longitude, altitude from bit 0 up.
// A push gives no result; a pop gives one item on m_axis: tdata holds found,
// out_valid, out_time, out_latitude, out_longitude, out_altitude, east,
// north, up, latest_time from bit 0 up.
// Sequence: one shared 32x32 multiplier is stepped over four partial
// products per multiply. After an accepted push s_axis_tready stays low
// through three multiplies and a write on a valid fix with an origin,
// through the write alone on an invalid fix, and on the first valid fix
// through two multiplies, then per cosine term a multiply, a reciprocal
// multiply and a correction step, nine terms, then the write. A pop reads
// the queue head in StPopRd and raises m_axis_tvalid in StPopOut.
// One request at a time: s_axis_tready is low while an item is at work or a
// result waits; a stalled receiver holds the result in the output register.
// Reset clears the origin, the latest time and the queue pointers; the
// queue storage itself is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none
module gps_enu_sample_queue_unit (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // fix_valid[0], fix_time[63:1], latitude[94:64], longitude[126:95],
  // altitude[154:127], zeros above
  input  wire logic [159:0] s_axis_tdata,
  // operation
  input  wire logic         s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // found[0], out_valid[1], out_time[64:2], out_latitude[95:65],
  // out_longitude[127:96], out_altitude[155:128], east[192:156],
  // north[228:193], up[256:229], latest_time[319:257]
  output logic      [319:0] m_axis_tdata
);
  gesq_pkg::state_e state_q, state_d;

  logic               fvalid_q, enu_q;
  logic [62:0]        ftime_q;
  logic signed [30:0] lat_q;
  logic signed [31:0] lon_q;
  logic signed [27:0] alt_q;

  logic               org_set_q;
  logic signed [30:0] org_lat_q;
  logic signed [31:0] org_lon_q;
  logic signed [27:0] org_alt_q;
  logic signed [31:0] org_cos_q;
  logic [62:0]        newest_q;
  logic [5:0]         head_q, count_q;

  logic [63:0]        x2_q, tmag_q, g_q, num_q;
  logic               tneg_q;
  logic [3:0]         k_q;
  logic [63:0]        prod_q;
  logic signed [36:0] east_q;
  logic signed [35:0] north_q;

  // shared multiplier
  logic        mul_start, mul_done;
  logic [63:0] mul_a, mul_b, mul_res;
  logic [5:0]  mul_s;

  gesq_mul u_mul (
    .clk_i, .rst_ni, .start_i(mul_start), .a_i(mul_a), .b_i(mul_b),
    .shift_i(mul_s), .done_o(mul_done), .res_o(mul_res)
  );

  logic               mul_run_q;
  logic signed [32:0] dlat, dlon;
  logic [63:0]        dlat_m, dlon_m, cos_m;
  logic signed [28:0] dalt;
  logic signed [27:0] up_v;

  assign dlat   = 33'(lat_q) - 33'(org_lat_q);
  assign dlon   = 33'(lon_q) - 33'(org_lon_q);
  assign dlat_m = dlat[32] ? 64'(-dlat) : 64'(dlat);
  assign dlon_m = dlon[32] ? 64'(-dlon) : 64'(dlon);
  assign cos_m  = org_cos_q[31] ? 64'(-33'(org_cos_q)) : 64'(33'(org_cos_q));
  assign dalt   = 29'(alt_q) - 29'(org_alt_q);
  assign up_v   = (dalt > 29'sd134217727)  ? 28'sh7FFFFFF :
                  (dalt < -29'sd134217728) ? 28'sh8000000 : 28'(dalt);

  // queue storage
  gesq_pkg::entry_t wr_ent, rd_ent;
  logic             ram_we;
  logic [5:0]       ram_addr, tail;
  logic [6:0]       tail_sum;
  logic             is_enu;

  assign is_enu   = enu_q;
  assign tail_sum = 7'(head_q) + 7'(count_q);
  assign tail     = (tail_sum >= 7'(gesq_pkg::QueueDepth)) ?
                    6'(tail_sum - 7'(gesq_pkg::QueueDepth)) : 6'(tail_sum);
  assign ram_we   = (state_q == gesq_pkg::StWrite);
  assign ram_addr = (ram_we && count_q != 6'(gesq_pkg::QueueDepth)) ? tail : head_q;

  always_comb begin
    wr_ent.valid    = fvalid_q;
    wr_ent.fix_time = ftime_q;
    wr_ent.lat      = lat_q;
    wr_ent.lon      = lon_q;
    wr_ent.alt      = alt_q;
    wr_ent.up       = is_enu ? up_v : 28'sd0;
    wr_ent.east     = is_enu ? east_q : 37'sd0;
    wr_ent.north    = is_enu ? north_q : 36'sd0;
  end

  gesq_ram #(.Width(gesq_pkg::EntryW), .Depth(gesq_pkg::QueueDepth)) u_ram (
    .clk_i, .we_i(ram_we), .addr_i(ram_addr), .wdata_i(wr_ent), .rdata_o(rd_ent)
  );

  // cosine step helpers
  logic [8:0]   dv;
  logic [44:0]  qd;
  logic [63:0]  q_v;
  logic signed [63:0] t_new;
  assign dv    = gesq_pkg::cos_div(k_q);
  // the rounded reciprocal product is the quotient or one above it
  assign qd    = 45'(prod_q[35:0]) * 45'(dv);
  assign q_v   = (64'(qd) > num_q) ? prod_q - 64'd1 : prod_q;
  assign t_new = gesq_pkg::OneQ30 - (tneg_q ? -$signed(q_v) : $signed(q_v));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      gesq_pkg::StIdle: begin
        if (s_axis_tvalid && s_axis_tready) begin
          if (s_axis_tuser == gesq_pkg::OpPop) state_d = gesq_pkg::StPopRd;
          else if (s_axis_tdata[0] && !org_set_q) state_d = gesq_pkg::StCosTh;
          else if (s_axis_tdata[0]) state_d = gesq_pkg::StNorth;
          else state_d = gesq_pkg::StWrite;
        end
      end
      gesq_pkg::StCosTh:   if (mul_done) state_d = gesq_pkg::StCosX2;
      gesq_pkg::StCosX2:   if (mul_done) state_d = gesq_pkg::StCosLoop;
      gesq_pkg::StCosLoop: if (mul_done) state_d = gesq_pkg::StCosRcp;
      gesq_pkg::StCosRcp:  if (mul_done) state_d = gesq_pkg::StCosDiv;
      gesq_pkg::StCosDiv:  state_d = (k_q == 4'd1) ? gesq_pkg::StWrite :
                                                     gesq_pkg::StCosLoop;
      gesq_pkg::StNorth:   if (mul_done) state_d = gesq_pkg::StEastG;
      gesq_pkg::StEastG:   if (mul_done) state_d = gesq_pkg::StEastM;
      gesq_pkg::StEastM:   if (mul_done) state_d = gesq_pkg::StWrite;
      gesq_pkg::StWrite:   state_d = gesq_pkg::StIdle;
      gesq_pkg::StPopRd:   state_d = gesq_pkg::StPopOut;
      gesq_pkg::StPopOut:  if (m_axis_tready) state_d = gesq_pkg::StIdle;
      default:             state_d = gesq_pkg::StIdle;
    endcase
  end

  // multiplier operands and handshake outputs
  always_comb begin
    mul_a = 64'd0;
    mul_b = 64'd0;
    mul_s = 6'd32;
    case (state_q)
      gesq_pkg::StCosTh: begin
        mul_a = 64'(lat_q[30] ? -32'(lat_q) : 32'(lat_q));
        mul_b = gesq_pkg::RadPerUnitQ62;
      end
      gesq_pkg::StCosX2:   begin mul_a = prod_q; mul_b = prod_q; mul_s = 6'd30; end
      gesq_pkg::StCosLoop: begin mul_a = x2_q; mul_b = tmag_q; mul_s = 6'd30; end
      gesq_pkg::StCosRcp: begin
        mul_a = num_q; mul_b = gesq_pkg::cos_rcp(k_q); mul_s = gesq_pkg::RcpShift;
      end
      gesq_pkg::StNorth:   begin mul_a = dlat_m; mul_b = gesq_pkg::MmPerUnitQ32; end
      gesq_pkg::StEastG: begin
        mul_a = dlon_m; mul_b = gesq_pkg::MmPerUnitQ32; mul_s = 6'd16;
      end
      gesq_pkg::StEastM:   begin mul_a = g_q; mul_b = cos_m; mul_s = 6'd46; end
      default: ;
    endcase
    mul_start     = !mul_run_q && (state_q == gesq_pkg::StCosTh ||
                    state_q == gesq_pkg::StCosX2 || state_q == gesq_pkg::StCosLoop ||
                    state_q == gesq_pkg::StCosRcp ||
                    state_q == gesq_pkg::StNorth || state_q == gesq_pkg::StEastG ||
                    state_q == gesq_pkg::StEastM);
    s_axis_tready = (state_q == gesq_pkg::StIdle);
    m_axis_tvalid = (state_q == gesq_pkg::StPopOut);
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= gesq_pkg::StIdle;
      mul_run_q <= 1'b0;
      org_set_q <= 1'b0;
      org_lat_q <= '0;
      org_lon_q <= '0;
      org_alt_q <= '0;
      org_cos_q <= '0;
      newest_q  <= '0;
      head_q    <= '0;
      count_q   <= '0;
    end else begin
      state_q <= state_d;
      if (mul_start) mul_run_q <= 1'b1;
      else if (mul_done) mul_run_q <= 1'b0;
      // latch the origin with its clamped cosine
      if (state_q == gesq_pkg::StCosDiv && k_q == 4'd1) begin
        org_set_q <= 1'b1;
        org_lat_q <= lat_q;
        org_lon_q <= lon_q;
        org_alt_q <= alt_q;
        org_cos_q <= (t_new > gesq_pkg::OneQ30) ? 32'sd1073741824 :
                     (t_new < -gesq_pkg::OneQ30) ? -32'sd1073741824 : 32'(t_new);
      end
      // advance queue pointers
      if (state_q == gesq_pkg::StWrite) begin
        newest_q <= ftime_q;
        if (count_q == 6'(gesq_pkg::QueueDepth)) begin
          head_q <= (head_q == 6'(gesq_pkg::QueueDepth - 1)) ? 6'd0 : head_q + 6'd1;
        end else begin
          count_q <= count_q + 6'd1;
        end
      end
      if (state_q == gesq_pkg::StPopOut && m_axis_tready && count_q != 6'd0) begin
        head_q  <= (head_q == 6'(gesq_pkg::QueueDepth - 1)) ? 6'd0 : head_q + 6'd1;
        count_q <= count_q - 6'd1;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      fvalid_q <= s_axis_tdata[0];
      enu_q    <= s_axis_tdata[0] && org_set_q;
      ftime_q  <= s_axis_tdata[63:1];
      lat_q    <= s_axis_tdata[94:64];
      lon_q    <= s_axis_tdata[126:95];
      alt_q    <= s_axis_tdata[154:127];
    end
    if (mul_done) prod_q <= mul_res;
    case (state_q)
      gesq_pkg::StCosX2: if (mul_done) begin
        x2_q <= mul_res; k_q <= 4'd9; tmag_q <= 64'(gesq_pkg::OneQ30); tneg_q <= 1'b0;
      end
      gesq_pkg::StCosLoop: if (mul_done) num_q <= mul_res + 64'(dv >> 1);
      gesq_pkg::StCosDiv: begin
        tneg_q <= t_new[63];
        tmag_q <= t_new[63] ? 64'(-t_new) : 64'(t_new);
        k_q    <= k_q - 4'd1;
      end
      gesq_pkg::StNorth: if (mul_done) north_q <= dlat[32] ? -36'(mul_res) : 36'(mul_res);
      gesq_pkg::StEastG: if (mul_done) g_q <= mul_res;
      gesq_pkg::StEastM: if (mul_done)
        east_q <= (dlon[32] != org_cos_q[31]) ? -37'(mul_res) : 37'(mul_res);
      default: ;
    endcase
  end

  // result item
  logic found;
  assign found = (count_q != 6'd0);
  assign m_axis_tdata = found ?
      {newest_q, rd_ent.up, rd_ent.north, rd_ent.east, rd_ent.alt, rd_ent.lon,
       rd_ent.lat, rd_ent.fix_time, rd_ent.valid, 1'b1} :
      {newest_q, 257'd0};
endmodule
`default_nettype wire

// File: tb/sv/gps_enu_sample_queue_unit_tb.sv
// ----------------------------------------------------------------------------
// GPS ENU sample queue testbench
// Drives pushes and pops over the input stream and predicts every pop result
// (queue entry, ENU offset, latest time). Each result item is checked field by
// field under random bursts, gaps and receiver stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none
module gps_enu_sample_queue_unit_tb;

  localparam int unsigned CycleCap  = 1000000;
  localparam int unsigned RingSize  = 64;
  localparam logic [63:0] PiFixed   = 64'h3243F6A8885A308D;
  localparam logic [63:0] MmScale   =
      (((PiFixed >> 28) * 64'd6378137) + 64'd900000) / 64'd1800000;
  localparam logic [63:0] RadScale  = (PiFixed + 64'd225000000) / 64'd450000000;
  localparam longint      UnitQ30   = 64'sd1073741824;

  typedef struct packed {
    logic               found;
    logic               valid;
    logic [62:0]        fix_time;
    logic signed [30:0] lat;
    logic signed [31:0] lon;
    logic signed [27:0] alt;
    logic signed [36:0] east;
    logic signed [35:0] north;
    logic signed [27:0] up;
    logic [62:0]        latest;
  } pop_result_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [159:0] s_axis_tdata = '0;
  logic         s_axis_tuser = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [319:0] m_axis_tdata;

  // fix store and origin held by the predictor
  gesq_pkg::entry_t   fix_store[gesq_pkg::QueueDepth];
  int                 store_head;
  int                 store_count;
  pop_result_t        want_ring[RingSize];
  int                 want_wr;
  int                 want_rd;
  logic               have_origin;
  logic signed [30:0] org_lat;
  logic signed [31:0] org_lon;
  logic signed [27:0] org_alt;
  longint             org_cos;
  logic [62:0]        last_push_time;

  int mismatches;
  int burst_left;
  int hold_request;
  int hold_left;
  int stall_mode;
  int cycle_count;

  gps_enu_sample_queue_unit uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // round(a*b / 2^s) on the full product
  function automatic logic [63:0] scaled_product(input logic [63:0] a, input logic [63:0] b,
                                                 input int s);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    p = p + (128'd1 << (s - 1));
    p = p >> s;
    return p[63:0];
  endfunction

  function automatic logic [63:0] magnitude(input longint x);
    return (x < 0) ? 64'(-x) : 64'(x);
  endfunction

  // cosine of the origin latitude in Q2.30 by Horner over the Taylor series
  function automatic longint origin_cosine(input longint lat);
    logic [63:0] th, x2, q, d;
    longint      t;
    th = scaled_product(magnitude(lat), RadScale, 32);
    x2 = scaled_product(th, th, 30);
    t  = UnitQ30;
    for (int k = 9; k >= 1; k--) begin
      d = 64'((2 * k) * (2 * k - 1));
      q = (scaled_product(x2, magnitude(t), 30) + d / 2) / d;
      t = UnitQ30 - ((t < 0) ? -longint'(q) : longint'(q));
    end
    if (t > UnitQ30) t = UnitQ30;
    if (t < -UnitQ30) t = -UnitQ30;
    return t;
  endfunction

  // advance the predictor by one accepted item
  task automatic predict_item(input logic op, input logic [159:0] d);
    gesq_pkg::entry_t e;
    pop_result_t      r;
    longint           dlat, dlon, u;
    logic [63:0]      nm, g, em;
    if (op == gesq_pkg::OpPush) begin
      e.valid = d[0];
      e.fix_time = d[63:1];
      e.lat = d[94:64];
      e.lon = d[126:95];
      e.alt = d[154:127];
      e.east = '0;
      e.north = '0;
      e.up = '0;
      if (e.valid && have_origin) begin
        dlat = longint'(e.lat) - longint'(org_lat);
        dlon = longint'(e.lon) - longint'(org_lon);
        nm = scaled_product(magnitude(dlat), MmScale, 32);
        g  = scaled_product(magnitude(dlon), MmScale, 16);
        em = scaled_product(g, magnitude(org_cos), 46);
        e.north = (dlat < 0) ? 36'(-longint'(nm)) : 36'(nm);
        e.east  = ((dlon < 0) != (org_cos < 0)) ? 37'(-longint'(em)) : 37'(em);
        u = longint'(e.alt) - longint'(org_alt);
        if (u > 134217727) u = 134217727;
        if (u < -134217728) u = -134217728;
        e.up = 28'(u);
      end else if (e.valid) begin
        have_origin = 1'b1;
        org_lat = e.lat;
        org_lon = e.lon;
        org_alt = e.alt;
        org_cos = origin_cosine(longint'(e.lat));
      end
      // drop the oldest when full
      if (store_count >= gesq_pkg::QueueDepth) begin
        store_head = (store_head + 1) % gesq_pkg::QueueDepth;
        store_count--;
      end
      fix_store[(store_head + store_count) % gesq_pkg::QueueDepth] = e;
      store_count++;
      last_push_time = e.fix_time;
    end else begin
      r = '0;
      r.latest = last_push_time;
      if (store_count > 0) begin
        e = fix_store[store_head];
        store_head = (store_head + 1) % gesq_pkg::QueueDepth;
        store_count--;
        r.found = 1'b1;
        r.valid = e.valid;
        r.fix_time = e.fix_time;
        r.lat = e.lat;
        r.lon = e.lon;
        r.alt = e.alt;
        r.east = e.east;
        r.north = e.north;
        r.up = e.up;
      end
      want_ring[want_wr % RingSize] = r;
      want_wr++;
    end
  endtask

  // offer one item, in bursts with random gaps between them
  task automatic send_item(input logic op, input logic [159:0] d);
    int   gap;
    logic ready;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 10);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= d;
    // sample ready ahead of each edge so the handshake is seen as the block sees it
    forever begin
      @(negedge clk_i);
      ready = s_axis_tready;
      @(posedge clk_i);
      if (ready) break;
    end
    predict_item(op, d);
  endtask

  task automatic push_fix(input logic v, input logic [62:0] t, input logic [30:0] lat,
                          input logic [31:0] lon, input logic [27:0] alt);
    send_item(gesq_pkg::OpPush, {5'd0, alt, lon, lat, t, v});
  endtask

  // pop with random ignored fix fields
  task automatic pop_fix();
    send_item(gesq_pkg::OpPop, {5'd0, 27'($urandom), $urandom, $urandom, $urandom, $urandom});
  endtask

  function automatic logic [30:0] random_lat();
    if ($urandom_range(0, 9) == 0) return 31'($urandom);
    return 31'($signed($urandom_range(0, 1800000000)) - 900000000);
  endfunction

  function automatic logic [31:0] random_lon();
    if ($urandom_range(0, 9) == 0) return $urandom;
    if ($urandom_range(0, 3) == 0)
      return 32'($signed(org_lon) + $signed($urandom_range(0, 2000)) - 1000);
    return 32'($signed($urandom_range(0, 32'd3600000000)) - 1800000000);
  endfunction

  function automatic logic [27:0] random_alt();
    if ($urandom_range(0, 9) == 0) return 28'($urandom);
    return 28'($signed($urandom_range(0, 101000000)) - 1000000);
  endfunction

  task automatic push_random();
    push_fix($urandom_range(0, 6) != 0, 63'({$urandom, $urandom}), random_lat(), random_lon(),
             random_alt());
  endtask

  task automatic test_empty_and_invalid();
    pop_fix();
    push_fix(1'b0, 63'h7FFF_FFFF_FFFF_FFFF, 31'sd900000000, 32'sd1800000000, 28'sd100000000);
    pop_fix();
    pop_fix();
  endtask

  // origin beyond -90 degrees gives a negative cosine; extremes follow
  task automatic test_origin_extremes();
    push_fix(1'b1, 63'd0, 31'h4000_0000, 32'd0, 28'h800_0000);
    push_fix(1'b1, 63'd1, 31'h3FFF_FFFF, 32'h7FFF_FFFF, 28'h7FF_FFFF);
    push_fix(1'b1, 63'h7FFF_FFFF_FFFF_FFFF, 31'h4000_0000, 32'h8000_0000, 28'h800_0000);
    push_fix(1'b1, 63'd12345, -31'sd900000000, -32'sd1800000000, -28'sd1000000);
    push_fix(1'b1, 63'd999, 31'sd900000000, 32'sd1800000000, 28'sd100000000);
    push_fix(1'b0, 63'd5, 31'sd1, 32'sd1, 28'sd1);
    push_fix(1'b1, 63'd6, 31'h4000_0001, 32'sd1, 28'sd0);
    repeat (8) pop_fix();
    pop_fix();
  endtask

  // overfill the store so the oldest entries drop
  task automatic test_overflow();
    repeat (gesq_pkg::QueueDepth + 5) push_random();
    repeat (gesq_pkg::QueueDepth + 1) pop_fix();
  endtask

  // receiver holds off while the sender keeps offering
  task automatic test_backpressure();
    hold_request = 400;
    repeat (3) push_random();
    repeat (6) pop_fix();
  endtask

  task automatic test_random_mix();
    int pop_pct;
    for (int n = 0; n < 400; n++) begin
      if (n % 60 == 0) pop_pct = $urandom_range(10, 70);
      if ($urandom_range(0, 99) < pop_pct) pop_fix();
      else push_random();
    end
    while (store_count > 0) pop_fix();
    pop_fix();
  endtask

  // check each result item against the oldest expectation
  always @(posedge clk_i) begin
    pop_result_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.found = m_axis_tdata[0];
      got.valid = m_axis_tdata[1];
      got.fix_time = m_axis_tdata[64:2];
      got.lat = m_axis_tdata[95:65];
      got.lon = m_axis_tdata[127:96];
      got.alt = m_axis_tdata[155:128];
      got.east = m_axis_tdata[192:156];
      got.north = m_axis_tdata[228:193];
      got.up = m_axis_tdata[256:229];
      got.latest = m_axis_tdata[319:257];
      if (want_rd == want_wr) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item %h", m_axis_tdata);
      end else begin
        want = want_ring[want_rd % RingSize];
        want_rd++;
        if (got.found !== want.found || got.valid !== want.valid ||
            got.fix_time !== want.fix_time || got.lat !== want.lat ||
            got.lon !== want.lon || got.alt !== want.alt || got.east !== want.east ||
            got.north !== want.north || got.up !== want.up || got.latest !== want.latest) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: found %0d/%0d valid %0d/%0d time %0d/%0d",
                     want.found, got.found, want.valid, got.valid,
                     want.fix_time, got.fix_time,
                     " lat %0d/%0d lon %0d/%0d alt %0d/%0d",
                     want.lat, got.lat, want.lon, got.lon, want.alt, got.alt,
                     " east %0d/%0d north %0d/%0d up %0d/%0d latest %0d/%0d",
                     want.east, got.east, want.north, got.north, want.up, got.up,
                     want.latest, got.latest);
        end
      end
    end
  end

  // receiver stall pattern, with a long hold on request
  always @(posedge clk_i) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (cycle_count % 64 == 0) stall_mode = $urandom_range(0, 2);
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      case (stall_mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= 1'($urandom_range(0, 1));
        default: m_axis_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // cycle limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleCap) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    mismatches = 0;
    burst_left = 0;
    hold_request = 0;
    hold_left = 0;
    stall_mode = 0;
    cycle_count = 0;
    store_head = 0;
    store_count = 0;
    want_wr = 0;
    want_rd = 0;
    have_origin = 1'b0;
    org_lat = '0;
    org_lon = '0;
    org_alt = '0;
    org_cos = 0;
    last_push_time = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_and_invalid();
    test_origin_extremes();
    test_overflow();
    test_backpressure();
    test_random_mix();
    s_axis_tvalid <= 1'b0;
    while (want_rd != want_wr) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (mismatches == 0 && want_rd == want_wr) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
`default_nettype wire
